/* src/rmvm_pkg.sv */
// ----------------------------------------------------------------------------
// rmvm_pkg
// Shared constants, controller states and width helpers for the running
// mean / variance / min / max block.
// ----------------------------------------------------------------------------
package rmvm_pkg;

	// default field widths
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF  = 24;

	// fixed result widths
	localparam int MEAN_W    = 24;
	localparam int VAR_W     = 39;
	// fraction bits of the scaled mean and variance (times 256)
	localparam int FRAC_BITS = 8;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACCUM,
		ST_MUL_GO,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

	// round a bit count up to whole bytes
	function automatic int pad8(input int w);
		return ((w + 7) / 8) * 8;
	endfunction

endpackage

/* src/rmvm_mul.sv */
// ----------------------------------------------------------------------------
// rmvm_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first,
// the partial product shifts right through the product register.
// ----------------------------------------------------------------------------
module rmvm_mul
	import rmvm_pkg::*;
#(
	parameter int A_W = 8,
	parameter int B_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [A_W-1:0]       a,
	input  logic [B_W-1:0]       b,
	output logic                 busy,
	output logic [A_W+B_W-1:0]   prod
);

	localparam int P_W   = A_W + B_W;
	localparam int CNT_W = $clog2(B_W + 1);

	logic [A_W-1:0]   a_q;
	logic [P_W-1:0]   prod_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [A_W:0]     sum;

	// add the multiplicand into the upper half when the current bit is set
	assign sum = {1'b0, prod_q[P_W-1:B_W]} + (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(B_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= P_W'(b);
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[B_W-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = prod_q;

endmodule

/* src/rmvm_div.sv */
// ----------------------------------------------------------------------------
// rmvm_div
// Bit-serial restoring divider: one dividend bit per cycle, MSB first,
// keeps the low quotient bits.
// ----------------------------------------------------------------------------
module rmvm_div
	import rmvm_pkg::*;
#(
	parameter int N_W = 16,
	parameter int D_W = 8,
	parameter int Q_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [N_W-1:0]   dividend,
	input  logic [D_W-1:0]   divisor,
	output logic             busy,
	output logic [Q_W-1:0]   quot
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [N_W-1:0]   num_q;
	logic [D_W-1:0]   den_q;
	logic [D_W-1:0]   rem_q;
	logic [Q_W-1:0]   quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [D_W:0]     trial;
	logic [D_W+1:0]   diff;
	logic             borrow;

	assign trial  = {rem_q, num_q[N_W-1]};
	assign diff   = {1'b0, trial} - {2'b00, den_q};
	assign borrow = diff[D_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(N_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[N_W-2:0], 1'b0};
			rem_q  <= borrow ? trial[D_W-1:0] : diff[D_W-1:0];
			quot_q <= {quot_q[Q_W-2:0], ~borrow};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

/* src/running_mean_variance_minmax.sv */
// ----------------------------------------------------------------------------
// running_mean_variance_minmax
// Running count, mean, sample variance, minimum and maximum of a stream of
// signed samples, computed exactly with bit-serial multipliers and dividers.
// ----------------------------------------------------------------------------
// Each input beat carries one signed sample. The block folds it into an exact
// count, sum and sum of squares (and into min and max), then answers with one
// output beat: the count, the mean times 256 (truncated toward zero), the
// sample variance times 256, (n*sumsq - sum^2)*256 / (n*(n-1)) truncated and
// zero below two samples, the min and max, and a flag in tuser that is set
// when the count was already at 2^COUNT_BITS-1 so that the sample only moved
// min and max. The products n*sumsq, sum^2 and n*(n-1) are formed side by
// side, one multiplier bit per cycle, then the variance divide runs one
// dividend bit per cycle over 2*(SAMPLE_BITS+COUNT_BITS)+8 bits, with the
// mean divide beside it. The input is ready only between samples; a finished
// result sits in the output register, so the next sample is taken while it
// waits for the sink.
// ----------------------------------------------------------------------------
module running_mean_variance_minmax
	import rmvm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input stream
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// tdata: sample
	input  logic [pad8(SAMPLE_BITS)-1:0] s_axis_tdata,
	// output stream
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// tdata: sample_count, mean_scaled, variance_scaled, smallest, largest
	output logic [pad8(COUNT_BITS + MEAN_W + VAR_W + 2*SAMPLE_BITS)-1:0] m_axis_tdata,
	// tuser: count_saturated
	output logic                m_axis_tuser
);

	localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;      // signed running sum
	localparam int SQ_W   = 2*SAMPLE_BITS + COUNT_BITS;    // sum of squares
	localparam int PROD_W = 2*SUM_W;                       // n*sumsq and sum^2
	localparam int NN_W   = 2*COUNT_BITS;                  // n*(n-1)
	localparam int OUT_FW = COUNT_BITS + MEAN_W + VAR_W + 2*SAMPLE_BITS;
	localparam int OUT_W  = pad8(OUT_FW);

	// controller
	state_t state_q, state_d;
	logic   mul_start, div_start, out_load, in_ready;
	logic   in_beat;

	// accumulated state
	logic [COUNT_BITS-1:0]    tally_q;
	logic [SUM_W-1:0]         sum_q;     // two's complement
	logic [SQ_W-1:0]          sqsum_q;
	logic [SAMPLE_BITS-1:0]   min_q;
	logic [SAMPLE_BITS-1:0]   max_q;
	logic                     sat_q;

	// sample staging
	logic [SAMPLE_BITS-1:0]   sample_q;
	logic [SAMPLE_BITS-1:0]   sample_abs;
	logic [2*SAMPLE_BITS-1:0] sq_s1;

	// serial arithmetic
	logic [SUM_W-1:0]         sum_abs;
	logic [COUNT_BITS-1:0]    tally_m1;
	logic [PROD_W-1:0]        nq_prod, ss_prod;
	logic [NN_W-1:0]          nn_prod;
	logic                     nq_busy, ss_busy, nn_busy, mul_busy;
	logic [PROD_W-1:0]        spread;
	logic [MEAN_W-1:0]        mean_quot;
	logic [VAR_W-1:0]         var_quot;
	logic                     mean_busy, var_busy, div_busy;

	// output register
	logic                     m_valid_q;
	logic [COUNT_BITS-1:0]    count_out_q;
	logic [MEAN_W-1:0]        mean_out_q;
	logic [VAR_W-1:0]         var_out_q;
	logic [SAMPLE_BITS-1:0]   min_out_q;
	logic [SAMPLE_BITS-1:0]   max_out_q;
	logic                     sat_out_q;

	assign in_beat = s_axis_tvalid && in_ready;

	// ------------------------------------------------------------------------
	// controller
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: state_d = ST_ACCUM;
			ST_ACCUM:  state_d = ST_MUL_GO;
			ST_MUL_GO: begin
				mul_start = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				// all three products settled: launch both divides
				if (!mul_busy) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// hold the result until the output register is free
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------------
	// sample capture, square and accumulation
	// ------------------------------------------------------------------------
	assign sample_abs = sample_q[SAMPLE_BITS-1] ? -sample_q : sample_q;

	always_ff @(posedge clk) begin
		if (in_beat) begin
			sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
		end
		if (state_q == ST_SQUARE) begin
			sq_s1 <= (2*SAMPLE_BITS)'(sample_abs) * (2*SAMPLE_BITS)'(sample_abs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			min_q   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			max_q   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			sat_q   <= 1'b0;
		end else if (state_q == ST_ACCUM) begin
			// count at its limit: only min and max move
			sat_q <= (tally_q == {COUNT_BITS{1'b1}});
			if (tally_q != {COUNT_BITS{1'b1}}) begin
				tally_q <= tally_q + COUNT_BITS'(1);
				sum_q   <= sum_q + {{COUNT_BITS{sample_q[SAMPLE_BITS-1]}}, sample_q};
				sqsum_q <= sqsum_q + {{COUNT_BITS{1'b0}}, sq_s1};
			end
			if ($signed(sample_q) < $signed(min_q)) begin
				min_q <= sample_q;
			end
			if ($signed(sample_q) > $signed(max_q)) begin
				max_q <= sample_q;
			end
		end
	end

	// ------------------------------------------------------------------------
	// products: n*sumsq, sum^2 and n*(n-1), in parallel
	// ------------------------------------------------------------------------
	assign sum_abs  = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign tally_m1 = tally_q - COUNT_BITS'(1);

	rmvm_mul #(
		.A_W (SQ_W),
		.B_W (COUNT_BITS)
	) u_mul_nq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (sqsum_q),
		.b      (tally_q),
		.busy   (nq_busy),
		.prod   (nq_prod)
	);

	rmvm_mul #(
		.A_W (SUM_W),
		.B_W (SUM_W)
	) u_mul_ss (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (sum_abs),
		.b      (sum_abs),
		.busy   (ss_busy),
		.prod   (ss_prod)
	);

	rmvm_mul #(
		.A_W (COUNT_BITS),
		.B_W (COUNT_BITS)
	) u_mul_nn (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (tally_q),
		.b      (tally_m1),
		.busy   (nn_busy),
		.prod   (nn_prod)
	);

	assign mul_busy = nq_busy || ss_busy || nn_busy;

	// never negative: n*sumsq >= sum^2
	assign spread = nq_prod - ss_prod;

	// ------------------------------------------------------------------------
	// divides: variance and mean, in parallel
	// ------------------------------------------------------------------------
	rmvm_div #(
		.N_W (PROD_W + FRAC_BITS),
		.D_W (NN_W),
		.Q_W (VAR_W)
	) u_div_var (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({spread, {FRAC_BITS{1'b0}}}),
		.divisor  (nn_prod),
		.busy     (var_busy),
		.quot     (var_quot)
	);

	rmvm_div #(
		.N_W (SUM_W + FRAC_BITS),
		.D_W (COUNT_BITS),
		.Q_W (MEAN_W)
	) u_div_mean (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_abs, {FRAC_BITS{1'b0}}}),
		.divisor  (tally_q),
		.busy     (mean_busy),
		.quot     (mean_quot)
	);

	assign div_busy = var_busy || mean_busy;

	// ------------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			count_out_q <= tally_q;
			// truncation toward zero: divide magnitudes, then restore the sign
			mean_out_q  <= sum_q[SUM_W-1] ? -mean_quot : mean_quot;
			// below two samples the divisor is zero; variance is defined as zero
			var_out_q   <= (tally_q < COUNT_BITS'(2)) ? '0 : var_quot;
			min_out_q   <= min_q;
			max_out_q   <= max_q;
			sat_out_q   <= sat_q;
		end
	end

	assign s_axis_tready = in_ready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_W'({max_out_q, min_out_q, var_out_q, mean_out_q, count_out_q});
	assign m_axis_tuser  = sat_out_q;

endmodule
